// ===== rtl/i2c_master_bit_engine_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared assertion shorthands for the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Opcodes, phase codes, widths and the result item type.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BIT_IDX_W = 4;
  localparam int unsigned OP_W      = 3;
  localparam logic [7:0]  HP_RESET  = 8'd5;

  typedef enum logic [OP_W-1:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_0 = 4'b0001,
    PH_1 = 4'b0010,
    PH_2 = 4'b0100,
    PH_3 = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                 scl_out;
    logic                 sda_out;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] read_data;
    logic                 ack_received;
  } res_t;

endpackage

// ===== rtl/i2cm_in_if.sv =====
// ----------------------------------------------------------------------------
// I2C master tick channel
// Valid/ready channel carrying one tick item: command and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  import i2cm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [BYTE_BITS-1:0] write_data;
  logic                 ack_value;
  logic                 sda_in;

  modport source (output valid, output opcode, output write_data, output ack_value,
                  output sda_in, input ready);
  modport sink   (input valid, input opcode, input write_data, input ack_value,
                  input sda_in, output ready);
endinterface

// ===== rtl/i2cm_out_if.sv =====
// ----------------------------------------------------------------------------
// I2C master result channel
// Valid/ready channel carrying one result item per tick.
// ----------------------------------------------------------------------------
interface i2cm_out_if;
  import i2cm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 scl_out;
  logic                 sda_out;
  logic                 busy_res;
  logic                 done_res;
  logic [BYTE_BITS-1:0] read_data;
  logic                 ack_received;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output read_data, output ack_received, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input read_data, input ack_received, output ready);
endinterface

// ===== rtl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer
// Command, phase and bit state with the single-pass next-state logic.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_macros.svh"

module i2cm_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [i2cm_pkg::OP_W-1:0]      opcode,
  input  logic [i2cm_pkg::BYTE_BITS-1:0] write_data,
  input  logic                           ack_value,
  input  logic                           sda_in,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  output i2cm_pkg::res_t                 res_nxt
);
  import i2cm_pkg::*;

  logic [7:0]                 hp_r;
  op_t                        cmd_r, cmd_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [7:0]                 tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0]       bit_r, bit_nxt;
  logic [BYTE_BITS-1:0]       shift_r, shift_nxt;
  logic                       scl_r, scl_nxt;
  logic                       sda_r, sda_nxt;
  logic                       ack_r, ack_nxt;
  logic [BYTE_BITS-1:0]       rd_r, rd_nxt;
  logic                       done;
  logic                       fin;
  logic [7:0]                 hp;
  logic [8:0]                 tick_inc;

  function automatic logic [BIT_IDX_W-1:0] bits_of(input op_t cmd);
    case (cmd)
      OP_WRITE: bits_of = BIT_IDX_W'(BYTE_BITS + 1);
      OP_READ:  bits_of = BIT_IDX_W'(BYTE_BITS);
      default:  bits_of = BIT_IDX_W'(1);
    endcase
  endfunction

  function automatic logic bit_value(input op_t cmd, input logic [BIT_IDX_W-1:0] bi,
                                     input logic [BYTE_BITS-1:0] sh);
    case (cmd)
      OP_WRITE: bit_value = (bi < BIT_IDX_W'(BYTE_BITS)) ? sh[~bi[2:0]] : 1'b1;
      OP_READ:  bit_value = 1'b1;
      default:  bit_value = sh[BYTE_BITS-1];
    endcase
  endfunction

  // returns {scl, sda}
  function automatic logic [1:0] levels(input op_t cmd, input phase_t ph,
                                        input logic [BIT_IDX_W-1:0] bi,
                                        input logic [BYTE_BITS-1:0] sh,
                                        input logic scl, input logic sda);
    logic s_c;
    logic s_d;
    s_c = scl;
    s_d = sda;
    case (cmd)
      OP_START: begin
        case (ph)
          PH_0:    s_d = 1'b1;
          PH_1:    s_c = 1'b1;
          PH_2:    s_d = 1'b0;
          default: s_c = 1'b0;
        endcase
      end
      OP_STOP: begin
        case (ph)
          PH_0:    s_d = 1'b0;
          PH_1:    s_c = 1'b1;
          default: s_d = 1'b1;
        endcase
      end
      default: begin
        case (ph)
          PH_0: begin
            s_c = 1'b0;
            s_d = bit_value(cmd, bi, sh);
          end
          PH_1:    s_c = 1'b1;
          default: s_c = 1'b0;
        endcase
      end
    endcase
    levels = {s_c, s_d};
  endfunction

  assign hp       = (hp_r == 8'd0) ? 8'd1 : hp_r;
  assign tick_inc = {1'b0, tick_r} + 9'd1;

  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rd_nxt    = rd_r;
    done      = 1'b0;
    fin       = 1'b0;
    if (cmd_r != OP_NONE) begin
      if (tick_inc >= {1'b0, hp}) begin
        tick_nxt = 8'd0;
        case (cmd_r)
          OP_START: begin
            if (phase_r == PH_3) fin = 1'b1;
            else phase_nxt = phase_t'({phase_r[2:0], 1'b0});
          end
          OP_STOP: begin
            if (phase_r == PH_2) fin = 1'b1;
            else phase_nxt = phase_t'({phase_r[2:0], 1'b0});
          end
          default: begin
            case (phase_r)
              PH_0: phase_nxt = PH_1;
              PH_1: begin
                if (cmd_r == OP_READ) shift_nxt = {shift_r[BYTE_BITS-2:0], sda_in};
                else if (cmd_r == OP_WRITE && bit_r == BIT_IDX_W'(BYTE_BITS))
                  ack_nxt = ~sda_in;
                bit_nxt   = bit_r + BIT_IDX_W'(1);
                phase_nxt = (bit_nxt < bits_of(cmd_r)) ? PH_0 : PH_2;
              end
              default: begin
                if (cmd_r == OP_READ) rd_nxt = shift_r;
                fin = 1'b1;
              end
            endcase
          end
        endcase
        if (fin) begin
          cmd_nxt   = OP_NONE;
          phase_nxt = PH_0;
          bit_nxt   = '0;
          done      = 1'b1;
        end else begin
          {scl_nxt, sda_nxt} = levels(cmd_r, phase_nxt, bit_nxt, shift_nxt, scl_r, sda_r);
        end
      end else begin
        tick_nxt = tick_inc[7:0];
      end
    end else if (opcode >= OP_START && opcode <= OP_ACK) begin
      cmd_nxt   = op_t'(opcode);
      phase_nxt = PH_0;
      tick_nxt  = 8'd0;
      bit_nxt   = '0;
      case (op_t'(opcode))
        OP_WRITE: shift_nxt = write_data;
        OP_READ:  shift_nxt = '0;
        OP_ACK:   shift_nxt = {ack_value, {(BYTE_BITS-1){1'b0}}};
        default:  shift_nxt = shift_r;
      endcase
      {scl_nxt, sda_nxt} = levels(cmd_nxt, PH_0, bit_nxt, shift_nxt, scl_r, sda_r);
    end
  end

  assign res_nxt = '{scl_out:      scl_nxt,
                     sda_out:      sda_nxt,
                     busy_res:     (cmd_nxt != OP_NONE),
                     done_res:     done,
                     read_data:    rd_nxt,
                     ack_received: ack_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r    <= HP_RESET;
      cmd_r   <= OP_NONE;
      phase_r <= PH_0;
      tick_r  <= 8'd0;
      bit_r   <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rd_r    <= '0;
    end else begin
      if (cfg_we) hp_r <= cfg_wdata;
      if (step) begin
        cmd_r   <= cmd_nxt;
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        rd_r    <= rd_nxt;
      end
    end
  end

  `I2CM_ASSERT_NOW(a_idle_clean, clk, rst_n, cmd_r == OP_NONE, phase_r == PH_0 && bit_r == '0 && tick_r == 8'd0, "idle with stale phase state")
  `I2CM_ASSERT_NOW(a_bit_range, clk, rst_n, 1'b1, bit_r <= BIT_IDX_W'(BYTE_BITS + 1), "bit index out of range")
  `I2CM_ASSERT_NXT(a_cmd_hold, clk, rst_n, cmd_r != OP_NONE && !(step && fin), cmd_r == $past(cmd_r), "command changed mid-sequence")

endmodule

// ===== rtl/i2cm_out_stage.sv =====
// ----------------------------------------------------------------------------
// I2C master result stage
// Result register with valid; frees the input side whenever it drains.
// ----------------------------------------------------------------------------
module i2cm_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  i2cm_pkg::res_t res_nxt,
  output logic           ready,
  i2cm_out_if.source     out_chan
);
  import i2cm_pkg::*;

  logic vld_r;
  res_t res_r;

  assign ready = ~vld_r | out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res_nxt;
  end

  assign out_chan.valid        = vld_r;
  assign out_chan.scl_out      = res_r.scl_out;
  assign out_chan.sda_out      = res_r.sda_out;
  assign out_chan.busy_res     = res_r.busy_res;
  assign out_chan.done_res     = res_r.done_res;
  assign out_chan.read_data    = res_r.read_data;
  assign out_chan.ack_received = res_r.ack_received;

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine
// Expands start, stop, write, read and ack commands into SCL/SDA levels,
// one tick item in, one result item out.
// ----------------------------------------------------------------------------
// channel   dir  handshake     contents
// in_chan   in   valid/ready   opcode, write_data, ack_value, sda_in
// out_chan  out  valid/ready   scl_out, sda_out, busy_res, done_res, read_data,
//                              ack_received
// cfg_*     in   write enable  half_period
//
// One item per cycle when not stalled; its result is registered the cycle after.
// The result register is the only stall point: in_chan.ready drops while a result
// waits and out_chan.ready is low.
// Synchronous active-low reset; half_period returns to 5, lines released.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_chan,
  i2cm_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import i2cm_pkg::*;

  logic stage_ready;
  logic step;
  res_t res_nxt;

  assign in_chan.ready = stage_ready;
  assign step          = in_chan.valid & stage_ready;

  i2cm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .opcode     (in_chan.opcode),
    .write_data (in_chan.write_data),
    .ack_value  (in_chan.ack_value),
    .sda_in     (in_chan.sda_in),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_nxt    (res_nxt)
  );

  i2cm_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .res_nxt  (res_nxt),
    .ready    (stage_ready),
    .out_chan (out_chan)
  );

endmodule
